@@ rtl/atw_pkg.sv @@
// ----------------------------------------------------------------------------
// atw_pkg: shared types and constants of the affine texture walker
// Operation codes, register indexes, field widths and the status word that
// the back end returns to the front end.
// ----------------------------------------------------------------------------
package atw_pkg;

	// input and output word field widths
	localparam int OP_W       = 2;
	localparam int TEX_IN_W   = 17;
	localparam int TEXEL_W    = 2;
	localparam int COLOR_W    = 8;
	localparam int ROW_W      = 8;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int COORD_W    = 32;

	// 16.16 coordinates, 256 texture columns
	localparam int FRAC_W     = 16;
	localparam int TEX_COL_W  = 8;
	localparam int TEX_COLS   = 256;

	// width used to range-check a load address against the store size
	localparam int LOAD_CMP_W = 20;
	// width of the wrapped texture row sum
	localparam int TROW_SUM_W = 11;

	// scroll advance per frame
	localparam logic [ROW_W-1:0] SCROLL_STEP   = 8'd4;
	localparam logic [ROW_W-1:0] END_ROW_RESET = 8'd240;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_LOAD  = 2'd0;
	localparam op_t OP_FRAME = 2'd1;
	localparam op_t OP_PIXEL = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_STEP_X    = 3'd0;
	localparam cfg_idx_t CFG_STEP_Y    = 3'd1;
	localparam cfg_idx_t CFG_ORIGIN_X  = 3'd2;
	localparam cfg_idx_t CFG_ORIGIN_Y  = 3'd3;
	localparam cfg_idx_t CFG_FIRST_ROW = 3'd4;
	localparam cfg_idx_t CFG_END_ROW   = 3'd5;

	// back end status seen by the front end
	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

@@ rtl/atw_queue.sv @@
// ----------------------------------------------------------------------------
// atw_queue: short work queue between front and back end
// Register-based FIFO of QUEUE_DEPTH words; full and valid come from a
// registered count.
// ----------------------------------------------------------------------------
module atw_queue #(
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head
);
	import atw_pkg::*;

	item_t               entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/atw_front.sv @@
// ----------------------------------------------------------------------------
// atw_front: item intake, register file and coordinate walker
// Decodes each input word, keeps the frame and raster state, steps the
// 16.16 texture coordinates and queues texel loads and drawn pixels with
// their ready-made memory addresses.
// ----------------------------------------------------------------------------
module atw_front #(
	parameter int  SCREEN_WIDTH  = 320,
	parameter int  SCREEN_HEIGHT = 240,
	parameter int  TEXTURE_ROWS  = 512,
	parameter type item_t        = logic
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input words
	input  logic                                in_valid,
	output logic                                in_stall,
	input  atw_pkg::op_t                        operation,
	input  logic [atw_pkg::TEX_IN_W-1:0]        texel_address,
	input  logic [atw_pkg::TEXEL_W-1:0]         texel_value,
	// register writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  atw_pkg::cfg_idx_t                   cfg_index,
	input  logic [atw_pkg::COORD_W-1:0]         cfg_data,
	// back end and queue
	input  atw_pkg::back_status_t               back_status,
	input  logic                                q_full,
	output logic                                q_push,
	output item_t                               q_item
);
	import atw_pkg::*;

	localparam int COL_W      = $clog2(SCREEN_WIDTH);
	localparam int TROW_W     = $clog2(TEXTURE_ROWS);
	localparam int TAW        = TROW_W + TEX_COL_W;
	localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int TRAIL_AW   = $clog2(2 * FRAME_SIZE);
	localparam int PIX_W      = $clog2(FRAME_SIZE + 1);
	localparam int MUL_W      = ROW_W + COL_W + 1;

	// configuration registers
	logic [COORD_W-1:0] step_x_q, step_y_q, origin_x_q, origin_y_q;
	logic [ROW_W-1:0]   first_row_q, end_row_q;

	// walker state
	logic               buffer_select_q, frame_buf_q;
	logic [ROW_W-1:0]   row_scroll_q, frame_scroll_q;
	logic [COORD_W-1:0] line_x_q, line_y_q, cur_x_q, cur_y_q;
	logic [COL_W-1:0]   column_q;
	logic [ROW_W-1:0]   row_q;
	logic [PIX_W-1:0]   pix_q;

	logic                    accept, is_load, is_frame, is_pixel;
	logic                    row_open, draw, col_last, frame_end;
	logic [ROW_W:0]          row_next;
	logic [TROW_SUM_W-1:0]   trow_sum, trow_wrap;
	logic [TAW-1:0]          tex_pix_addr;
	logic [LOAD_CMP_W-1:0]   load_wide;
	logic                    load_ok;
	logic [TRAIL_AW-1:0]     trail_addr;
	logic [PIX_W-1:0]        pix_start;
	logic [COORD_W-1:0]      line_x_next, line_y_next;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full | back_status.clearing;
	assign accept    = in_valid & ~in_stall;

	// operation decode
	always_comb begin
		is_load  = 1'b0;
		is_frame = 1'b0;
		is_pixel = 1'b0;
		unique case (operation)
			OP_LOAD:  is_load  = 1'b1;
			OP_FRAME: is_frame = 1'b1;
			OP_PIXEL: is_pixel = 1'b1;
			default:  ;
		endcase
	end

	// raster position checks
	assign row_open  = (row_q < end_row_q) && (32'(row_q) < SCREEN_HEIGHT);
	assign draw      = accept & is_pixel & row_open & (32'(column_q) < SCREEN_WIDTH);
	assign col_last  = (column_q == COL_W'(SCREEN_WIDTH - 1));
	assign row_next  = {1'b0, row_q} + 1'b1;
	assign frame_end = (row_next >= {1'b0, end_row_q}) || (32'(row_next) >= SCREEN_HEIGHT);

	// texel address: scrolled row wrapped at the store height
	assign trow_sum  = TROW_SUM_W'(cur_y_q[FRAC_W +: TEX_COL_W]) + TROW_SUM_W'(frame_scroll_q);
	assign trow_wrap = (trow_sum >= TROW_SUM_W'(TEXTURE_ROWS)) ?
	                   trow_sum - TROW_SUM_W'(TEXTURE_ROWS) : trow_sum;
	assign tex_pix_addr = {trow_wrap[TROW_W-1:0], cur_x_q[FRAC_W +: TEX_COL_W]};

	// load range check
	assign load_wide = LOAD_CMP_W'(texel_address);
	assign load_ok   = load_wide < LOAD_CMP_W'(TEXTURE_ROWS * TEX_COLS);

	// trail address: linear pixel index in the frame's buffer
	assign trail_addr = frame_buf_q ? TRAIL_AW'(FRAME_SIZE) + TRAIL_AW'(pix_q)
	                                : TRAIL_AW'(pix_q);
	assign pix_start  = PIX_W'(MUL_W'(first_row_q) * MUL_W'(SCREEN_WIDTH));

	assign line_x_next = line_x_q - step_y_q;
	assign line_y_next = line_y_q + step_x_q;

	// queue word
	assign q_push = accept & ((is_load & load_ok) | draw);
	always_comb begin
		q_item            = '0;
		q_item.pixel      = is_pixel;
		q_item.tex_addr   = is_pixel ? tex_pix_addr : TAW'(load_wide);
		q_item.tex_value  = texel_value;
		q_item.trail_addr = trail_addr;
		q_item.column     = column_q;
		q_item.row        = row_q;
		q_item.last       = col_last & frame_end;
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q    <= '0;
			step_y_q    <= '0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			first_row_q <= '0;
			end_row_q   <= END_ROW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_STEP_X:    step_x_q    <= cfg_data;
				CFG_STEP_Y:    step_y_q    <= cfg_data;
				CFG_ORIGIN_X:  origin_x_q  <= cfg_data;
				CFG_ORIGIN_Y:  origin_y_q  <= cfg_data;
				CFG_FIRST_ROW: first_row_q <= cfg_data[ROW_W-1:0];
				CFG_END_ROW:   end_row_q   <= cfg_data[ROW_W-1:0];
				default:       ;
			endcase
		end
	end

	// frame and raster walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_select_q <= 1'b0;
			frame_buf_q     <= 1'b0;
			row_scroll_q    <= '0;
			frame_scroll_q  <= '0;
			line_x_q        <= '0;
			line_y_q        <= '0;
			cur_x_q         <= '0;
			cur_y_q         <= '0;
			column_q        <= '0;
			row_q           <= '0;
			pix_q           <= '0;
		end else if (accept && is_frame) begin
			frame_buf_q     <= buffer_select_q;
			frame_scroll_q  <= row_scroll_q;
			buffer_select_q <= ~buffer_select_q;
			row_scroll_q    <= row_scroll_q + SCROLL_STEP;
			row_q           <= first_row_q;
			column_q        <= '0;
			line_x_q        <= origin_x_q;
			line_y_q        <= origin_y_q;
			cur_x_q         <= origin_x_q;
			cur_y_q         <= origin_y_q;
			pix_q           <= pix_start;
		end else if (draw) begin
			pix_q <= pix_q + 1'b1;
			if (col_last) begin
				// next row starts from the rotated line origin
				column_q <= '0;
				row_q    <= row_q + 1'b1;
				line_x_q <= line_x_next;
				line_y_q <= line_y_next;
				cur_x_q  <= line_x_next;
				cur_y_q  <= line_y_next;
			end else begin
				column_q <= column_q + 1'b1;
				cur_x_q  <= cur_x_q + step_x_q;
				cur_y_q  <= cur_y_q + step_y_q;
			end
		end
	end

endmodule

@@ rtl/atw_back.sv @@
// ----------------------------------------------------------------------------
// atw_back: texture store, trail buffers and pixel output
// Executes queued words: loads write the texture store, pixels read texel
// and old trail value, blend, write back and leave through an output
// register. Clears both trail buffers after reset.
// ----------------------------------------------------------------------------
module atw_back #(
	parameter int  SCREEN_WIDTH  = 320,
	parameter int  SCREEN_HEIGHT = 240,
	parameter int  TEXTURE_ROWS  = 512,
	parameter type item_t        = logic
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// queue head
	input  logic                                 head_valid,
	input  item_t                                head,
	output logic                                 pop,
	// status to front end
	output atw_pkg::back_status_t                status,
	// result words
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [atw_pkg::COLOR_W-1:0]          color_index,
	output logic [$clog2(SCREEN_WIDTH)-1:0]      pixel_x,
	output logic [atw_pkg::ROW_W-1:0]            pixel_y,
	output logic                                 frame_last
);
	import atw_pkg::*;

	localparam int TEX_DEPTH   = TEXTURE_ROWS * TEX_COLS;
	localparam int TRAIL_DEPTH = 2 * SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int TRAIL_AW    = $clog2(TRAIL_DEPTH);

	logic [TEXEL_W-1:0] tex_mem   [TEX_DEPTH];
	logic [COLOR_W-1:0] trail_mem [TRAIL_DEPTH];

	// read stage
	logic               valid_s1;
	item_t              item_s1;
	logic [TEXEL_W-1:0] tex_rd_s1;
	logic [COLOR_W-1:0] trail_rd_s1;
	logic               fwd_hit_s1;
	logic [COLOR_W-1:0] fwd_data_s1;

	// clear sweep
	logic                clear_q;
	logic [TRAIL_AW-1:0] clear_cnt_q;

	logic                out_valid_q;
	logic                s1_adv, s1_load, load_pop;
	logic [COLOR_W-1:0]  old_val, blend;
	logic                trail_we;
	logic [TRAIL_AW-1:0] trail_wa;
	logic [COLOR_W-1:0]  trail_wd;

	assign status.clearing = clear_q;

	// stage handshakes
	assign s1_adv   = valid_s1 & (~out_valid_q | ~out_stall);
	assign s1_load  = head_valid & head.pixel & (~valid_s1 | s1_adv) & ~clear_q;
	assign load_pop = head_valid & ~head.pixel;
	assign pop      = s1_load | load_pop;

	// blend with the freshest trail value
	assign old_val = fwd_hit_s1 ? fwd_data_s1 : trail_rd_s1;
	assign blend   = {tex_rd_s1, old_val[COLOR_W-1:TEXEL_W]};

	// trail write port: clear sweep or pixel write-back
	assign trail_we = clear_q | s1_adv;
	assign trail_wa = clear_q ? clear_cnt_q : item_s1.trail_addr;
	assign trail_wd = clear_q ? '0 : blend;

	// texture store
	always_ff @(posedge clk) begin
		if (load_pop) begin
			tex_mem[head.tex_addr] <= head.tex_value;
		end
		if (s1_load) begin
			tex_rd_s1 <= tex_mem[head.tex_addr];
		end
	end

	// trail buffers, read-first
	always_ff @(posedge clk) begin
		if (trail_we) begin
			trail_mem[trail_wa] <= trail_wd;
		end
		if (s1_load) begin
			trail_rd_s1 <= trail_mem[head.trail_addr];
		end
	end

	// read stage payload, forwarding of a same-cycle write
	always_ff @(posedge clk) begin
		if (s1_load) begin
			item_s1     <= head;
			fwd_hit_s1  <= trail_we && (trail_wa == head.trail_addr);
			fwd_data_s1 <= trail_wd;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			color_index <= blend;
			pixel_x     <= item_s1.column;
			pixel_y     <= item_s1.row;
			frame_last  <= item_s1.last;
		end
	end

	// control: stage valids and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			clear_q     <= 1'b1;
			clear_cnt_q <= '0;
		end else begin
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (clear_q) begin
				clear_cnt_q <= clear_cnt_q + 1'b1;
				if (clear_cnt_q == TRAIL_AW'(TRAIL_DEPTH - 1)) begin
					clear_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/affine_texture_walker_with_trail_unit.sv @@
// ----------------------------------------------------------------------------
// affine_texture_walker_with_trail_unit: rotozoom pixel engine with trail
// Walks 16.16 texture coordinates over the screen raster, samples a 2-bit
// texture and blends each texel into a double-buffered fading trail.
//
//   channel | handshake                | word
//   --------+--------------------------+----------------------------------------
//   in      | in_valid / in_stall      | operation, texel_address, texel_value
//   out     | out_valid / out_stall    | color_index, pixel_x, pixel_y, frame_last
//   cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One input word per cycle while in_stall is low; a drawn pixel is presented
// after intake via queue write, texel/trail read and output register.
// After reset all 2*SCREEN_WIDTH*SCREEN_HEIGHT trail entries (153600 at default
// size) are swept to zero, one entry per cycle, with in_stall high.
// Register writes are taken at any time. out_stall backs up into the
// four-word queue; intake stalls only when it is full or during the clear.
// ----------------------------------------------------------------------------
module affine_texture_walker_with_trail_unit #(
	parameter int SCREEN_WIDTH  = 320,
	parameter int SCREEN_HEIGHT = 240,
	parameter int TEXTURE_ROWS  = 512
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  atw_pkg::op_t                        operation,
	input  logic [atw_pkg::TEX_IN_W-1:0]        texel_address,
	input  logic [atw_pkg::TEXEL_W-1:0]         texel_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [atw_pkg::COLOR_W-1:0]         color_index,
	output logic [$clog2(SCREEN_WIDTH)-1:0]     pixel_x,
	output logic [atw_pkg::ROW_W-1:0]           pixel_y,
	output logic                                frame_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  atw_pkg::cfg_idx_t                   cfg_index,
	input  logic [atw_pkg::COORD_W-1:0]         cfg_data
);
	import atw_pkg::*;

	localparam int COL_W    = $clog2(SCREEN_WIDTH);
	localparam int TAW      = $clog2(TEXTURE_ROWS) + TEX_COL_W;
	localparam int TRAIL_AW = $clog2(2 * SCREEN_WIDTH * SCREEN_HEIGHT);

	// queued work word
	typedef struct packed {
		logic                pixel;
		logic [TAW-1:0]      tex_addr;
		logic [TEXEL_W-1:0]  tex_value;
		logic [TRAIL_AW-1:0] trail_addr;
		logic [COL_W-1:0]    column;
		logic [ROW_W-1:0]    row;
		logic                last;
	} item_t;

	back_status_t back_status;
	logic         q_push, q_full, q_pop, q_head_valid;
	item_t        q_item, q_head;

	atw_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.TEXTURE_ROWS (TEXTURE_ROWS),
		.item_t       (item_t)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.texel_address(texel_address),
		.texel_value  (texel_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.back_status  (back_status),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	atw_queue #(
		.item_t(item_t)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head      (q_head)
	);

	atw_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.TEXTURE_ROWS (TEXTURE_ROWS),
		.item_t       (item_t)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.status     (back_status),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.color_index(color_index),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.frame_last (frame_last)
	);

`ifndef SYNTHESIS
	// no pixel can come out while the trail buffers are being cleared
	a_no_out_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.clearing |-> !out_valid)
		else $error("pixel emitted during trail clear");

	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue overflow");

	// the frame's last pixel is always at the right edge
	a_last_at_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> (pixel_x == COL_W'(SCREEN_WIDTH - 1)))
		else $error("frame_last away from the right edge");
`endif

endmodule

@@ verif/tb_affine_texture_walker_with_trail_unit.sv @@
// ----------------------------------------------------------------------------
// tb_affine_texture_walker_with_trail_unit: self-checking bench of the walker
// A short list of hand-written words runs first. Some carry expected pixels
// worked out by hand. Random phases follow, each with its own register
// settings. A scoreboard in the bench walks the same coordinates and blends
// the same trail, and every output word is compared field by field. Both
// channels idle at random, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_affine_texture_walker_with_trail_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import atw_pkg::*;

	localparam int SCR_W     = 320;
	localparam int SCR_H     = 240;
	localparam int TEX_ROWS  = 512;
	localparam int X_W       = $clog2(SCR_W);
	localparam int TEX_DEPTH = TEX_ROWS * TEX_COLS;
	localparam int FRAME_PIX = SCR_W * SCR_H;

	// operation code with no meaning, and a register index with no register
	localparam op_t      OP_SPARE   = 2'd3;
	localparam cfg_idx_t CFG_UNUSED = 3'd7;

	localparam int DRAIN_CYCLES   = 8;
	// covers the trail clear after reset several times over
	localparam int WATCHDOG_LIMIT = 500000;
	localparam int NUM_PHASES     = 7;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [X_W-1:0]     px_x;
		logic [ROW_W-1:0]   px_y;
		logic               last;
	} pixel_word_t;

	typedef struct {
		op_t                 op;
		logic [TEX_IN_W-1:0] addr;
		logic [TEXEL_W-1:0]  val;
		bit                  typed;
		pixel_word_t         px;
	} warmup_row_t;

	// DUT ports
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	op_t                 operation = OP_LOAD;
	logic [TEX_IN_W-1:0] texel_address = '0;
	logic [TEXEL_W-1:0]  texel_value = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [COLOR_W-1:0]  color_index;
	logic [X_W-1:0]      pixel_x;
	logic [ROW_W-1:0]    pixel_y;
	logic                frame_last;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_idx_t            cfg_index = CFG_STEP_X;
	logic [COORD_W-1:0]  cfg_data = '0;

	// scoreboard state
	logic [TEXEL_W-1:0] texels [TEX_DEPTH];
	bit                 texel_loaded [TEX_DEPTH];
	logic [COLOR_W-1:0] trail [2*FRAME_PIX];
	bit                 sel_next, frame_sel;
	logic [ROW_W-1:0]   scroll_next, frame_scroll;
	logic [COORD_W-1:0] line_x, line_y, walk_x, walk_y;
	int unsigned        col, row;
	logic [COORD_W-1:0] step_x, step_y, org_x, org_y;
	logic [ROW_W-1:0]   first_row, end_row;

	pixel_word_t expected_pixels [$];
	logic [COORD_W-1:0] reg_vals [6];
	warmup_row_t warmup [21];
	int  fail_count = 0;
	int  idle_cycles = 0;
	bit  in_quiet = 1'b0;
	bit  out_quiet = 1'b0;

	affine_texture_walker_with_trail_unit #(
		.SCREEN_WIDTH (SCR_W),
		.SCREEN_HEIGHT(SCR_H),
		.TEXTURE_ROWS (TEX_ROWS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.texel_address(texel_address),
		.texel_value  (texel_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.color_index  (color_index),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.frame_last   (frame_last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned row_limit();
		return (end_row < SCR_H) ? end_row : SCR_H;
	endfunction

	// texel the next pixel word reads; 0 when the frame is already done
	function automatic bit texel_for_pixel(output int unsigned addr);
		int unsigned trow, tcol;
		addr = 0;
		if (row >= row_limit() || col >= SCR_W) return 1'b0;
		trow = (int'(walk_y[FRAC_W +: TEX_COL_W]) + int'(frame_scroll)) % TEX_ROWS;
		tcol = 32'(walk_x[FRAC_W +: TEX_COL_W]);
		addr = trow * TEX_COLS + tcol;
		return 1'b1;
	endfunction

	// advance the scoreboard by one accepted word, queue any pixel it draws
	task automatic walk_word(op_t op, logic [TEX_IN_W-1:0] addr, logic [TEXEL_W-1:0] val,
			bit typed, pixel_word_t typed_px);
		int unsigned ta, idx;
		logic [COLOR_W-1:0] clr;
		pixel_word_t px;
		case (op)
			OP_LOAD: begin
				if (int'(addr) < TEX_DEPTH) begin
					texels[addr] = val;
					texel_loaded[addr] = 1'b1;
				end
			end
			OP_FRAME: begin
				frame_sel = sel_next;
				frame_scroll = scroll_next;
				sel_next = ~sel_next;
				scroll_next = scroll_next + SCROLL_STEP;
				row = 32'(first_row);
				col = 0;
				line_x = org_x;
				line_y = org_y;
				walk_x = org_x;
				walk_y = org_y;
			end
			OP_PIXEL: begin
				if (texel_for_pixel(ta)) begin
					idx = (frame_sel ? FRAME_PIX : 0) + row * SCR_W + col;
					clr = {texels[ta], 6'b0} | (trail[idx] >> 2);
					trail[idx] = clr;
					px.color = clr;
					px.px_x = X_W'(col);
					px.px_y = ROW_W'(row);
					px.last = (col == SCR_W - 1) && (row + 1 >= row_limit());
					expected_pixels.push_back(typed ? typed_px : px);
					walk_x += step_x;
					walk_y += step_y;
					col++;
					if (col >= SCR_W) begin
						col = 0;
						row++;
						line_x -= step_y;
						line_y += step_x;
						walk_x = line_x;
						walk_y = line_y;
					end
				end
			end
			default: ;
		endcase
	endtask

	// drive one input word after a random gap and wait until it is taken
	task automatic send_word(op_t op, logic [TEX_IN_W-1:0] addr, logic [TEXEL_W-1:0] val,
			bit typed = 1'b0, pixel_word_t typed_px = '0);
		int unsigned gap;
		gap = in_quiet ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		texel_address <= addr;
		texel_value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		walk_word(op, addr, val, typed, typed_px);
		if ($urandom_range(0, 59) == 0) in_quiet = !in_quiet;
	endtask

	// a texel is loaded before the first pixel that reads it
	task automatic send_pixel();
		int unsigned ta;
		if (texel_for_pixel(ta) && !texel_loaded[ta])
			send_word(OP_LOAD, TEX_IN_W'(ta), TEXEL_W'($urandom_range(0, 3)));
		send_word(OP_PIXEL, TEX_IN_W'($urandom), TEXEL_W'($urandom));
	endtask

	// write all six registers from reg_vals, optionally the spare index too
	task automatic program_regs(bit poke_unused);
		int n_writes;
		cfg_idx_t idx;
		logic [COORD_W-1:0] data;
		n_writes = poke_unused ? 7 : 6;
		for (int i = 0; i < n_writes; i++) begin
			idx = (i < 6) ? cfg_idx_t'(i) : CFG_UNUSED;
			data = (i < 6) ? reg_vals[i] : COORD_W'($urandom);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (idx)
				CFG_STEP_X:    step_x = data;
				CFG_STEP_Y:    step_y = data;
				CFG_ORIGIN_X:  org_x = data;
				CFG_ORIGIN_Y:  org_y = data;
				CFG_FIRST_ROW: first_row = data[ROW_W-1:0];
				CFG_END_ROW:   end_row = data[ROW_W-1:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// no input pending, every pixel back, then a drain wait for loads in flight
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] pick_step();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1, 2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
			default: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
		endcase
	endfunction

	// row register data with junk in the unused upper bits
	function automatic logic [COORD_W-1:0] row_word(logic [ROW_W-1:0] r);
		return (COORD_W'($urandom) & 32'hFFFF_FF00) | COORD_W'(r);
	endfunction

	task automatic note_fail(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endtask

	// stimulus
	initial begin : stimulus
		int phase_len [NUM_PHASES];
		int unsigned ta, r;
		logic [ROW_W-1:0] fr;
		int er;
		bit drawing;

		// most drawn pixels bring a texel load along, so phases stay short
		phase_len = '{480, 70, 40, 30, 420, 60, 60};
		for (int i = 0; i < TEX_DEPTH; i++) begin
			texels[i] = '0;
			texel_loaded[i] = 1'b0;
		end
		for (int i = 0; i < 2*FRAME_PIX; i++) trail[i] = '0;
		sel_next = 1'b0; frame_sel = 1'b0;
		scroll_next = '0; frame_scroll = '0;
		line_x = '0; line_y = '0; walk_x = '0; walk_y = '0;
		col = 0; row = 0;
		step_x = '0; step_y = '0; org_x = '0; org_y = '0;
		first_row = '0; end_row = END_ROW_RESET;

		// registers stay at reset values for the hand-written part
		warmup = '{
			'{OP_LOAD,  17'd0,      2'd3, 1'b0, '0},
			'{OP_LOAD,  17'd131071, 2'd3, 1'b0, '0},
			'{OP_LOAD,  17'd1,      2'd0, 1'b0, '0},
			// before any frame start: row 0, buffer 0, scroll 0
			'{OP_PIXEL, 17'd0,      2'd0, 1'b1, '{8'hC0, 9'd0, 8'd0, 1'b0}},
			'{OP_PIXEL, 17'd131071, 2'd3, 1'b1, '{8'hC0, 9'd1, 8'd0, 1'b0}},
			'{OP_SPARE, 17'd131071, 2'd3, 1'b0, '0},
			'{OP_PIXEL, 17'd0,      2'd0, 1'b1, '{8'hC0, 9'd2, 8'd0, 1'b0}},
			// first frame reuses buffer 0, old value shows up faded
			'{OP_FRAME, 17'd0,      2'd0, 1'b0, '0},
			'{OP_PIXEL, 17'd0,      2'd0, 1'b1, '{8'hF0, 9'd0, 8'd0, 1'b0}},
			'{OP_PIXEL, 17'd0,      2'd0, 1'b1, '{8'hF0, 9'd1, 8'd0, 1'b0}},
			'{OP_PIXEL, 17'd0,      2'd0, 1'b1, '{8'hF0, 9'd2, 8'd0, 1'b0}},
			'{OP_PIXEL, 17'd0,      2'd0, 1'b1, '{8'hC0, 9'd3, 8'd0, 1'b0}},
			// second frame: buffer 1, scroll 4
			'{OP_LOAD,  17'd1024,   2'd2, 1'b0, '0},
			'{OP_FRAME, 17'd131071, 2'd3, 1'b0, '0},
			'{OP_PIXEL, 17'd0,      2'd0, 1'b1, '{8'h80, 9'd0, 8'd0, 1'b0}},
			// third frame: back to buffer 0, scroll 8
			'{OP_LOAD,  17'd0,      2'd0, 1'b0, '0},
			'{OP_LOAD,  17'd2048,   2'd1, 1'b0, '0},
			'{OP_FRAME, 17'd0,      2'd0, 1'b0, '0},
			'{OP_PIXEL, 17'd0,      2'd0, 1'b1, '{8'h7C, 9'd0, 8'd0, 1'b0}},
			'{OP_PIXEL, 17'd0,      2'd0, 1'b1, '{8'h7C, 9'd1, 8'd0, 1'b0}},
			'{OP_PIXEL, 17'd65535,  2'd1, 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (warmup[i])
			send_word(warmup[i].op, warmup[i].addr, warmup[i].val, warmup[i].typed,
				warmup[i].px);

		// random phases, each with its own register setting
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			reg_vals[CFG_STEP_X]   = pick_step();
			reg_vals[CFG_STEP_Y]   = pick_step();
			reg_vals[CFG_ORIGIN_X] = $urandom;
			reg_vals[CFG_ORIGIN_Y] = $urandom;
			fr = ROW_W'($urandom_range(0, SCR_H - 1));
			er = fr + $urandom_range(1, 3);
			if (er > SCR_H) er = SCR_H;
			case (p)
				0: begin
					// single bottom row, so frames finish
					fr = 8'd239; er = 240;
				end
				1: begin
					reg_vals[CFG_STEP_X]   = 32'h7FFF_FFFF;
					reg_vals[CFG_STEP_Y]   = 32'h8000_0000;
					reg_vals[CFG_ORIGIN_X] = 32'h8000_0000;
					reg_vals[CFG_ORIGIN_Y] = 32'h7FFF_FFFF;
					fr = 8'd0; er = 255;
				end
				2: begin
					// empty frame
					reg_vals[CFG_STEP_X]   = 32'h8000_0000;
					reg_vals[CFG_STEP_Y]   = 32'h7FFF_FFFF;
					reg_vals[CFG_ORIGIN_X] = 32'h7FFF_FFFF;
					reg_vals[CFG_ORIGIN_Y] = 32'h8000_0000;
					fr = 8'd239; er = 1;
				end
				3: begin
					// rows below the screen
					fr = 8'd255; er = 255;
				end
				4: begin
					reg_vals[CFG_STEP_X] = '0;
					reg_vals[CFG_STEP_Y] = '0;
					er = fr + 1;
				end
				6: er = SCR_H;
				default: ;
			endcase
			reg_vals[CFG_FIRST_ROW] = row_word(fr);
			reg_vals[CFG_END_ROW]   = row_word(ROW_W'(er));
			program_regs(p == 3);
			if ($urandom_range(0, 3) != 0)
				send_word(OP_FRAME, TEX_IN_W'($urandom), TEXEL_W'($urandom));

			for (int n = 0; n < phase_len[p]; n++) begin
				drawing = texel_for_pixel(ta);
				r = $urandom_range(0, 399);
				if (drawing ? (r == 0) : (r < 50))
					send_word(OP_FRAME, TEX_IN_W'($urandom), TEXEL_W'($urandom));
				else if (r < 56)
					send_word(OP_SPARE, TEX_IN_W'($urandom), TEXEL_W'($urandom));
				else if (r < 76)
					send_word(OP_LOAD, TEX_IN_W'($urandom), TEXEL_W'($urandom));
				else
					send_pixel();
			end
		end

		wait_idle();
		if (expected_pixels.size() != 0)
			note_fail($sformatf("%0d pixels never came out", expected_pixels.size()));
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// output side stalls, with quiet stretches
	always begin : stall_gen
		int unsigned hold;
		@(posedge clk);
		if (!out_quiet && ((out_valid && !out_stall) || $urandom_range(0, 15) == 0)) begin
			hold = $urandom_range(0, 14);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
		if ($urandom_range(0, 299) == 0) out_quiet = !out_quiet;
	end

	// compare each accepted output word with the oldest expected pixel
	always @(posedge clk) begin : pixel_check
		pixel_word_t want, got;
		if (out_valid && !out_stall) begin
			got = '{color_index, pixel_x, pixel_y, frame_last};
			if (expected_pixels.size() == 0) begin
				note_fail($sformatf("unexpected pixel color %02h x %0d y %0d last %0b",
					got.color, got.px_x, got.px_y, got.last));
			end else begin
				want = expected_pixels.pop_front();
				if (got.color !== want.color || got.px_x !== want.px_x ||
						got.px_y !== want.px_y || got.last !== want.last)
					note_fail($sformatf(
						"mismatch: exp %02h x %0d y %0d last %0b, got %02h x %0d y %0d last %0b",
						want.color, want.px_x, want.px_y, want.last,
						got.color, got.px_x, got.px_y, got.last));
			end
		end
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
